### rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and constants
// Segment table sizing, segment record, request kinds, status codes and
// sequencer states of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int SEG_MAX   = 64;
    localparam int SEG_IDX_W = $clog2(SEG_MAX);
    localparam int SEG_CNT_W = SEG_IDX_W + 1;
    localparam int ADDR_W    = 32;
    localparam int ALIGN_W   = 17;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_ALIGNED = 2'd1;
    localparam logic [1:0] KIND_FREE    = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_SIZE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]    start;
        logic [ADDR_W-1:0]    len;
        logic                 free;
        logic [SEG_IDX_W-1:0] next;
        logic [SEG_IDX_W-1:0] prev;
    } t_seg;

    typedef enum logic [5:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_RD, S_A_EV, S_A_CHK2, S_A_USE,
        S_SP_NEW, S_SP_CUR, S_SP_RNX, S_SP_WNX, S_SP_END,
        S_F_RD, S_F_EV, S_F_RNX, S_F_CNX, S_F_RI, S_F_RPV, S_F_CPV,
        S_M_RA, S_M_RB, S_M_GB, S_M_WA, S_M_RN, S_M_WN, S_M_CK,
        S_M_RL, S_M_WB, S_M_R1, S_M_R2, S_M_W2, S_M_R3, S_M_R4, S_M_W4,
        S_FIN
    } t_state;

endpackage

### rtl/first_fit_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top: first-fit heap segment allocator
// Keeps an address-ordered circular linked table of heap segments in one
// memory and serves allocate, aligned allocate and free requests.
// Slave item: tuser = kind, tdata = byte_count, alignment, address. Master
// item, one per request and none for the unused kind: tdata = result
// address, tuser = status. Write heap_base (index 0), then heap_size
// (index 1), only while idle; the size write rebuilds the table.
// One item at a time. After the accept a request passes dispatch, then walks
// the segments, reading and checking each one. An allocation splits the
// segment that fits where it is too long (an aligned one up to twice, with a
// second check), marks it used and finishes; one that finds no fit, or is
// refused in dispatch, goes straight to finish. A free that finds its segment
// marks it free and does up to two merges. tready rises with the result
// valid. After reset and each heap_size write the root segment is written
// with tready low. A finished result waits in the output register while the
// next item is taken; that item waits at its end until the result is taken.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [87:0] i_s_axis_tdata,   // byte_count[31:0], alignment[48:32], address[80:49]
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // result_address[31:0]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    localparam int IW = ffsa_pkg::SEG_IDX_W;
    localparam int CW = ffsa_pkg::SEG_CNT_W;
    localparam int AW = ffsa_pkg::ADDR_W;
    localparam int LW = ffsa_pkg::ALIGN_W;

    ffsa_pkg::t_seg r_mem [ffsa_pkg::SEG_MAX];
    ffsa_pkg::t_seg r_rd;
    logic           mem_we;
    logic [IW-1:0]  mem_wa;
    logic [IW-1:0]  mem_ra;
    ffsa_pkg::t_seg mem_wd;

    ffsa_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic           r_pend, n_pend;
    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_base, r_size;
    logic [1:0]     r_kind, n_kind;
    logic [AW:0]    r_n, n_n;
    logic [LW-1:0]  r_mask, n_mask;
    logic [AW-1:0]  r_addr, n_addr;
    logic [IW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_steps, n_steps;
    ffsa_pkg::t_seg r_cur, n_cur, r_new, n_new, r_ea, n_ea, r_eb, n_eb;
    logic [IW-1:0]  r_s, n_s;
    logic [AW-1:0]  r_k, n_k;
    logic [AW-1:0]  r_gap, n_gap;
    logic [1:0]     r_ph, n_ph;
    logic [IW-1:0]  r_ma, n_ma, r_mb, n_mb, r_last, n_last, r_t, n_t;
    logic           r_alast, n_alast;
    logic [AW-1:0]  r_res, n_res;
    logic [1:0]     r_stat, n_stat;
    logic           r_ovalid, n_ovalid;
    logic [AW-1:0]  r_odata, n_odata;
    logic [1:0]     r_ouser, n_ouser;

    logic [AW-1:0]  gap;
    logic [AW-1:0]  in_bc;
    logic [LW-1:0]  in_align;
    logic [IW-1:0]  s_next;
    logic           walk_end;

    assign in_bc    = i_s_axis_tdata[31:0];
    assign in_align = i_s_axis_tdata[48:32];
    assign s_next   = r_count[IW-1:0] + IW'(1);
    assign walk_end = (r_rd.next == '0) || ((r_steps + CW'(1)) > r_count);
    assign gap      = (r_kind == ffsa_pkg::KIND_ALIGNED)
                    ? ((AW'(0) - r_rd.start) & AW'(r_mask)) : '0;

    assign o_s_axis_tready = (r_state == ffsa_pkg::S_IDLE) && !r_pend;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    always_comb begin
        n_state = r_state;  n_ret = r_ret;    n_pend = r_pend;   n_count = r_count;
        n_kind = r_kind;    n_n = r_n;        n_mask = r_mask;   n_addr = r_addr;
        n_idx = r_idx;      n_steps = r_steps; n_cur = r_cur;    n_new = r_new;
        n_ea = r_ea;        n_eb = r_eb;      n_s = r_s;         n_k = r_k;
        n_gap = r_gap;      n_ph = r_ph;      n_ma = r_ma;       n_mb = r_mb;
        n_last = r_last;    n_t = r_t;        n_alast = r_alast; n_res = r_res;
        n_stat = r_stat;    n_ovalid = r_ovalid; n_odata = r_odata; n_ouser = r_ouser;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = r_rd;
        mem_ra = '0;

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ffsa_pkg::S_IDLE: begin
                if (r_pend) begin
                    mem_we  = 1'b1;
                    mem_wa  = '0;
                    mem_wd  = '{start: r_base, len: r_size, free: 1'b1, next: '0, prev: '0};
                    n_count = '0;
                    n_pend  = 1'b0;
                end else if (i_s_axis_tvalid) begin
                    n_kind  = i_s_axis_tuser;
                    n_n     = (({1'b0, in_bc}) + (AW+1)'(3)) & ~(AW+1)'(3);
                    n_mask  = (in_align == '0) ? '0 : in_align - LW'(1);
                    n_addr  = i_s_axis_tdata[80:49];
                    n_idx   = '0;
                    n_steps = '0;
                    n_state = ffsa_pkg::S_DISPATCH;
                end
            end
            ffsa_pkg::S_DISPATCH: begin
                n_res = '0;
                priority if (r_kind == ffsa_pkg::KIND_UNUSED) begin
                    n_state = ffsa_pkg::S_IDLE;
                end else if (r_kind == ffsa_pkg::KIND_FREE) begin
                    n_state = ffsa_pkg::S_F_RD;
                end else if ((r_kind == ffsa_pkg::KIND_ALLOC &&
                              r_count >= CW'(ffsa_pkg::SEG_MAX - 1)) ||
                             (r_kind == ffsa_pkg::KIND_ALIGNED &&
                              ({1'b0, r_count} + (CW+1)'(2)) >
                              (CW+1)'(ffsa_pkg::SEG_MAX - 1))) begin
                    n_stat  = ffsa_pkg::ST_FULL;
                    n_state = ffsa_pkg::S_FIN;
                end else begin
                    n_state = ffsa_pkg::S_A_RD;
                end
            end
            ffsa_pkg::S_A_RD: begin
                mem_ra  = r_idx;
                n_state = ffsa_pkg::S_A_EV;
            end
            ffsa_pkg::S_A_EV: begin
                if (r_rd.free && ({2'b0, r_rd.len} >= ({2'b0, gap} + {1'b0, r_n}))) begin
                    n_cur = r_rd;
                    n_gap = gap;
                    if (r_kind == ffsa_pkg::KIND_ALLOC) begin
                        if ({1'b0, r_rd.len} > r_n) begin
                            n_k     = r_n[AW-1:0];
                            n_ph    = 2'd0;
                            n_state = ffsa_pkg::S_SP_NEW;
                        end else begin
                            n_state = ffsa_pkg::S_A_USE;
                        end
                    end else if ({1'b0, r_rd.len - gap} > r_n) begin
                        n_k     = r_n[AW-1:0] + gap;
                        n_ph    = 2'd1;
                        n_state = ffsa_pkg::S_SP_NEW;
                    end else begin
                        n_state = ffsa_pkg::S_A_CHK2;
                    end
                end else if (walk_end) begin
                    n_stat  = ffsa_pkg::ST_NO_FIT;
                    n_state = ffsa_pkg::S_FIN;
                end else begin
                    n_idx   = r_rd.next;
                    n_steps = r_steps + CW'(1);
                    n_state = ffsa_pkg::S_A_RD;
                end
            end
            ffsa_pkg::S_A_CHK2: begin
                if ({1'b0, r_cur.len} > r_n) begin
                    n_k     = r_gap;
                    n_ph    = 2'd2;
                    n_state = ffsa_pkg::S_SP_NEW;
                end else begin
                    n_state = ffsa_pkg::S_A_USE;
                end
            end
            ffsa_pkg::S_A_USE: begin
                mem_we      = 1'b1;
                mem_wa      = r_idx;
                mem_wd      = r_cur;
                mem_wd.free = 1'b0;
                n_res       = r_cur.start;
                n_stat      = ffsa_pkg::ST_OK;
                n_state     = ffsa_pkg::S_FIN;
            end
            ffsa_pkg::S_SP_NEW: begin
                mem_we  = 1'b1;
                mem_wa  = s_next;
                mem_wd  = '{start: r_cur.start + r_k, len: r_cur.len - r_k,
                            free: r_cur.free, next: r_cur.next, prev: r_idx};
                n_new   = mem_wd;
                n_s     = s_next;
                n_state = ffsa_pkg::S_SP_CUR;
            end
            ffsa_pkg::S_SP_CUR: begin
                n_cur      = r_cur;
                n_cur.len  = r_k;
                n_cur.next = r_s;
                if (r_cur.next == r_idx) begin
                    n_cur.prev = r_s;
                end
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = n_cur;
                n_count = {1'b0, r_s};
                n_state = (r_cur.next == r_idx) ? ffsa_pkg::S_SP_END : ffsa_pkg::S_SP_RNX;
            end
            ffsa_pkg::S_SP_RNX: begin
                mem_ra  = r_new.next;
                n_state = ffsa_pkg::S_SP_WNX;
            end
            ffsa_pkg::S_SP_WNX: begin
                mem_we      = 1'b1;
                mem_wa      = r_new.next;
                mem_wd      = r_rd;
                mem_wd.prev = r_s;
                n_state     = ffsa_pkg::S_SP_END;
            end
            ffsa_pkg::S_SP_END: begin
                unique case (r_ph)
                    2'd1: n_state = ffsa_pkg::S_A_CHK2;
                    2'd2: begin
                        n_cur   = r_new;
                        n_idx   = r_s;
                        n_state = ffsa_pkg::S_A_USE;
                    end
                    default: n_state = ffsa_pkg::S_A_USE;
                endcase
            end
            ffsa_pkg::S_F_RD: begin
                mem_ra  = r_idx;
                n_state = ffsa_pkg::S_F_EV;
            end
            ffsa_pkg::S_F_EV: begin
                if (r_rd.start == r_addr) begin
                    n_cur      = r_rd;
                    n_cur.free = 1'b1;
                    mem_we     = 1'b1;
                    mem_wa     = r_idx;
                    mem_wd     = n_cur;
                    n_state    = ffsa_pkg::S_F_RNX;
                end else if (walk_end) begin
                    n_stat  = ffsa_pkg::ST_NOT_FOUND;
                    n_state = ffsa_pkg::S_FIN;
                end else begin
                    n_idx   = r_rd.next;
                    n_steps = r_steps + CW'(1);
                    n_state = ffsa_pkg::S_F_RD;
                end
            end
            ffsa_pkg::S_F_RNX: begin
                mem_ra  = r_cur.next;
                n_state = ffsa_pkg::S_F_CNX;
            end
            ffsa_pkg::S_F_CNX: begin
                if (r_rd.free && r_cur.next != '0) begin
                    n_ma    = r_idx;
                    n_ret   = ffsa_pkg::S_F_RI;
                    n_state = ffsa_pkg::S_M_RA;
                end else begin
                    n_ma    = r_idx;
                    n_state = ffsa_pkg::S_F_RI;
                end
            end
            ffsa_pkg::S_F_RI: begin
                mem_ra  = r_ma;
                n_state = ffsa_pkg::S_F_RPV;
            end
            ffsa_pkg::S_F_RPV: begin
                mem_ra = r_rd.prev;
                n_t    = r_rd.prev;
                if (r_ma == '0) begin
                    n_stat  = ffsa_pkg::ST_OK;
                    n_state = ffsa_pkg::S_FIN;
                end else begin
                    n_state = ffsa_pkg::S_F_CPV;
                end
            end
            ffsa_pkg::S_F_CPV: begin
                n_stat = ffsa_pkg::ST_OK;
                if (r_rd.free) begin
                    n_ma    = r_t;
                    n_ret   = ffsa_pkg::S_FIN;
                    n_state = ffsa_pkg::S_M_RA;
                end else begin
                    n_state = ffsa_pkg::S_FIN;
                end
            end
            ffsa_pkg::S_M_RA: begin
                mem_ra  = r_ma;
                n_state = ffsa_pkg::S_M_RB;
            end
            ffsa_pkg::S_M_RB: begin
                mem_ra  = r_rd.next;
                n_ea    = r_rd;
                n_mb    = r_rd.next;
                n_state = ffsa_pkg::S_M_GB;
            end
            ffsa_pkg::S_M_GB: begin
                n_eb    = r_rd;
                n_state = ffsa_pkg::S_M_WA;
            end
            ffsa_pkg::S_M_WA: begin
                mem_we      = 1'b1;
                mem_wa      = r_ma;
                mem_wd      = r_ea;
                mem_wd.len  = r_ea.len + r_eb.len;
                mem_wd.next = r_eb.next;
                if (r_eb.next == r_ma) begin
                    mem_wd.prev = r_ma;
                end
                n_last  = r_count[IW-1:0];
                n_alast = (r_ma == r_count[IW-1:0]);
                n_count = r_count - CW'(1);
                n_state = (r_eb.next == r_ma) ? ffsa_pkg::S_M_CK : ffsa_pkg::S_M_RN;
            end
            ffsa_pkg::S_M_RN: begin
                mem_ra  = r_eb.next;
                n_state = ffsa_pkg::S_M_WN;
            end
            ffsa_pkg::S_M_WN: begin
                mem_we      = 1'b1;
                mem_wa      = r_eb.next;
                mem_wd      = r_rd;
                mem_wd.prev = r_ma;
                n_state     = ffsa_pkg::S_M_CK;
            end
            ffsa_pkg::S_M_CK: begin
                n_state = (r_mb != r_last) ? ffsa_pkg::S_M_RL : r_ret;
            end
            ffsa_pkg::S_M_RL: begin
                mem_ra  = r_last;
                n_state = ffsa_pkg::S_M_WB;
            end
            ffsa_pkg::S_M_WB: begin
                mem_we = 1'b1;
                mem_wa = r_mb;
                mem_wd = r_rd;
                if (r_alast) begin
                    n_ma = r_mb;
                end
                n_state = ffsa_pkg::S_M_R1;
            end
            ffsa_pkg::S_M_R1: begin
                mem_ra  = r_mb;
                n_state = ffsa_pkg::S_M_R2;
            end
            ffsa_pkg::S_M_R2: begin
                mem_ra  = r_rd.prev;
                n_t     = r_rd.prev;
                n_state = ffsa_pkg::S_M_W2;
            end
            ffsa_pkg::S_M_W2: begin
                mem_we      = 1'b1;
                mem_wa      = r_t;
                mem_wd      = r_rd;
                mem_wd.next = r_mb;
                n_state     = ffsa_pkg::S_M_R3;
            end
            ffsa_pkg::S_M_R3: begin
                mem_ra  = r_mb;
                n_state = ffsa_pkg::S_M_R4;
            end
            ffsa_pkg::S_M_R4: begin
                mem_ra  = r_rd.next;
                n_t     = r_rd.next;
                n_state = ffsa_pkg::S_M_W4;
            end
            ffsa_pkg::S_M_W4: begin
                mem_we      = 1'b1;
                mem_wa      = r_t;
                mem_wd      = r_rd;
                mem_wd.prev = r_mb;
                n_state     = r_ret;
            end
            ffsa_pkg::S_FIN: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                    n_ouser  = r_stat;
                    n_state  = ffsa_pkg::S_IDLE;
                end
            end
            default: n_state = ffsa_pkg::S_IDLE;
        endcase

        if (i_cfg_we && i_cfg_idx == ffsa_pkg::CFG_HEAP_SIZE) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffsa_pkg::S_IDLE;
            r_ret    <= ffsa_pkg::S_FIN;
            r_pend   <= 1'b1;
            r_count  <= '0;
            r_base   <= '0;
            r_size   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_pend   <= n_pend;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                if (i_cfg_idx == ffsa_pkg::CFG_HEAP_BASE) begin
                    r_base <= i_cfg_wdata;
                end else begin
                    r_size <= i_cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;   r_n     <= n_n;     r_mask <= n_mask;  r_addr <= n_addr;
        r_idx   <= n_idx;    r_steps <= n_steps; r_cur  <= n_cur;   r_new  <= n_new;
        r_ea    <= n_ea;     r_eb    <= n_eb;    r_s    <= n_s;     r_k    <= n_k;
        r_gap   <= n_gap;    r_ph    <= n_ph;    r_ma   <= n_ma;    r_mb   <= n_mb;
        r_last  <= n_last;   r_t     <= n_t;     r_alast <= n_alast;
        r_res   <= n_res;    r_stat  <= n_stat;  r_odata <= n_odata; r_ouser <= n_ouser;
    end

endmodule
